FILE: design/mwo_pkg.sv
// shared types and constants for the multi-waveform oscillator
`default_nettype none

package mwo_pkg;

  typedef enum logic [2:0] {
    WAVE_SINE   = 3'd0,
    WAVE_SQUARE = 3'd1,
    WAVE_FOLD   = 3'd2,
    WAVE_BENT   = 3'd3,
    WAVE_PULSE  = 3'd4,
    WAVE_SUB    = 3'd5,
    WAVE_SAW    = 3'd6,
    WAVE_NOISE  = 3'd7
  } wave_t;

  localparam logic CFG_WAVE_SELECT = 1'b0;
  localparam logic CFG_PULSE_WIDTH = 1'b1;

  localparam int PHASE_FRAC_BITS_DEF = 16;
  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int  SINE_AMP     = 16384;
  localparam int  SINE_DW      = 15;

  localparam logic signed [15:0] Q_ONE     = 16'sd16384;
  localparam logic signed [15:0] Q_FIFTH   = 16'sd3277;
  localparam logic signed [15:0] BEND_COEF = 16'sd4915;
  localparam logic signed [31:0] BEND_RND  = 32'sd8192;

  localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;
  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

  localparam wave_t       WAVE_RESET  = WAVE_SQUARE;
  localparam logic [15:0] PULSE_RESET = 16'd19661;

endpackage

`default_nettype wire

FILE: design/mwo_sine_rom.sv
// quarter-wave sine rom with two registered read ports
`default_nettype none

module mwo_sine_rom import mwo_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [SINE_TABLE_BITS:0]   addr_a,
  input  wire logic [SINE_TABLE_BITS:0]   addr_b,
  output logic      [SINE_DW-1:0]         data_a,
  output logic      [SINE_DW-1:0]         data_b
);

  localparam int QN = 1 << SINE_TABLE_BITS;
  localparam real ANG_STEP = 1.5707963267948966 / real'(QN);

  typedef logic [SINE_DW-1:0] qtab_t [QN+1];

  function automatic qtab_t build_rom();
    qtab_t t;
    real   ang;
    for (int i = 0; i <= QN; i++) begin
      ang  = ANG_STEP * real'(i);
      t[i] = SINE_DW'($rtoi(real'(SINE_AMP) * $sin(ang) + 0.5));
    end
    return t;
  endfunction

  localparam qtab_t SINE_ROM = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= SINE_ROM[addr_a];
      data_b <= SINE_ROM[addr_b];
    end
  end

endmodule

`default_nettype wire

FILE: design/multi_waveform_oscillator.sv
// multi-waveform oscillator top level: phase in, one q2.14 sample out
// One phase request is taken every cycle when the output side keeps up. Each
// phase passes in order through the input register, the sine rom read
// register and the output register. The two-port quarter-wave rom of
// 2^SINE_TABLE_BITS+1 entries is read once per request and bounds the stage it
// sits in; the bent sine adds one 16x16 constant multiply behind it. Stall from
// the output propagates back through the three stages, bubbles are squeezed out.
// The noise lfsr steps only when a noise request leaves the input register.
`default_nettype none

module multi_waveform_oscillator import mwo_pkg::*; #(
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         phase_valid,
  output logic                              phase_stall,
  input  wire logic [PHASE_FRAC_BITS:0]     phase,
  output logic                              sample_valid,
  input  wire logic                         sample_stall,
  output logic signed [15:0]                sample,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic                         cfg_index,
  input  wire logic [15:0]                  cfg_data
);

  localparam int P  = PHASE_FRAC_BITS;
  localparam int S  = SINE_TABLE_BITS;
  localparam int A  = S + 2;
  localparam logic [S:0]   QN_IDX = (S+1)'(1 << S);
  localparam logic [P-1:0] HALF   = P'(1 << (P - 1));

  function automatic logic [A-1:0] to_angle(input logic [P-1:0] x);
    logic [P+A-1:0] w;
    w = {x, {A{1'b0}}};
    return w[P+A-1 -: A];
  endfunction

  function automatic logic [S:0] rom_index(input logic [A-1:0] a);
    return a[S] ? (QN_IDX - {1'b0, a[S-1:0]}) : {1'b0, a[S-1:0]};
  endfunction

  // configuration
  wave_t       wave_select;
  logic [15:0] pulse_width;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_select <= WAVE_RESET;
      pulse_width <= PULSE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WAVE_SELECT: wave_select <= wave_t'(cfg_data[2:0]);
        CFG_PULSE_WIDTH: pulse_width <= cfg_data;
      endcase
    end
  end

  // pipeline flow
  logic v0, v1;
  logic free0, free1, out_free;

  assign out_free    = !sample_valid || !sample_stall;
  assign free1       = !v1 || out_free;
  assign free0       = !v0 || free1;
  assign phase_stall = !free0;

  // stage 0: input register
  logic [P:0] ph0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (free0) begin
      v0 <= phase_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free0 && phase_valid) begin
      ph0 <= phase;
    end
  end

  logic [P-1:0]   c0;
  logic           h0;
  logic           first_half;
  logic [P-1:0]   c3;
  logic [A-1:0]   ang_a, ang_b;
  logic [P-1:0]   saw_u;
  logic [P+14:0]  saw_w;
  logic [14:0]    saw_v;
  logic [31:0]    lfsr, lfsr_src, lfsr_next;
  logic signed [15:0] direct0;

  assign c0         = ph0[P-1:0];
  assign h0         = ph0[P];
  assign first_half = !c0[P-1];
  assign c3         = c0 + {c0[P-2:0], 1'b0};
  assign ang_a      = to_angle(c0);
  assign ang_b      = (wave_select == WAVE_FOLD) ? to_angle(c3 + HALF) : to_angle(c3);
  assign saw_u      = c0 + HALF;
  assign saw_w      = {saw_u, 15'd0};
  assign saw_v      = saw_w[P+14 -: 15];

  always_comb begin
    lfsr_src  = (lfsr == '0) ? LFSR_SEED : lfsr;
    lfsr_next = lfsr_src[0] ? ((lfsr_src >> 1) ^ LFSR_MASK) : (lfsr_src >> 1);
  end

  always_comb begin
    case (wave_select)
      WAVE_PULSE: direct0 = ({c0, 16'd0} < {pulse_width, {P{1'b0}}}) ? Q_ONE : -Q_ONE;
      WAVE_SUB: begin
        if (first_half) direct0 = h0 ? Q_FIFTH : Q_ONE;
        else            direct0 = h0 ? -Q_ONE : -Q_FIFTH;
      end
      WAVE_SAW:   direct0 = $signed({1'b0, saw_v}) - Q_ONE;
      WAVE_NOISE: direct0 = $signed({1'b0, lfsr_next[31:17]}) - Q_ONE;
      default:    direct0 = first_half ? Q_ONE : -Q_ONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= LFSR_SEED;
    end else if (free1 && v0 && wave_select == WAVE_NOISE) begin
      lfsr <= lfsr_next;
    end
  end

  // stage 1: rom read register
  wave_t              mode1;
  logic               neg_a1, neg_b1;
  logic signed [15:0] direct1;
  logic [SINE_DW-1:0] rd_a, rd_b;

  mwo_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk    (clk),
    .en     (free1),
    .addr_a (rom_index(ang_a)),
    .addr_b (rom_index(ang_b)),
    .data_a (rd_a),
    .data_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (free1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      mode1   <= wave_select;
      neg_a1  <= ang_a[A-1];
      neg_b1  <= ang_b[A-1];
      direct1 <= direct0;
    end
  end

  logic signed [15:0] sin_a, sin_b, bend, result;
  logic signed [31:0] prod, prod_rnd;

  assign sin_a    = neg_a1 ? -$signed({1'b0, rd_a}) : $signed({1'b0, rd_a});
  assign sin_b    = neg_b1 ? -$signed({1'b0, rd_b}) : $signed({1'b0, rd_b});
  assign prod     = BEND_COEF * sin_b;
  assign prod_rnd = (prod + BEND_RND) >>> 14;
  assign bend     = prod_rnd[15:0];

  always_comb begin
    case (mode1)
      WAVE_SINE: result = sin_a;
      WAVE_FOLD: result = sin_b;
      WAVE_BENT: result = sin_a + bend;
      default:   result = direct1;
    endcase
  end

  // stage 2: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (out_free) begin
      sample_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && v1) begin
      sample <= result;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    phase_stall |-> (v0 && v1 && sample_valid && sample_stall))
    else $error("input stalled with room in the pipeline");

  a_stage1_blocked: assert property (@(posedge clk) disable iff (rst)
    (v1 && !free1) |-> (sample_valid && sample_stall))
    else $error("stage 1 held while output free");

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (rst)
    lfsr != '0)
    else $error("noise lfsr reached zero");

  a_lfsr_steps_on_noise: assert property (@(posedge clk) disable iff (rst)
    !(free1 && v0 && wave_select == WAVE_NOISE) |=> $stable(lfsr))
    else $error("noise lfsr moved without a noise request");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// self-checking testbench for the multi-waveform oscillator
module testbench import mwo_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PFB = PHASE_FRAC_BITS_DEF;
  localparam int STB = SINE_TABLE_BITS_DEF;
  localparam int QN = 1 << STB;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic phase_valid = 1'b0;
  logic phase_stall;
  logic [PFB:0] phase = '0;
  logic sample_valid;
  logic sample_stall = 1'b0;
  logic signed [15:0] sample;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_WAVE_SELECT;
  logic [15:0] cfg_data = '0;

  multi_waveform_oscillator #(
    .PHASE_FRAC_BITS(PFB),
    .SINE_TABLE_BITS(STB)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .phase_valid(phase_valid),
    .phase_stall(phase_stall),
    .phase(phase),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial forever #6 clk = ~clk;

  int quarter_rom [0:QN];
  wave_t wave_model;
  logic [15:0] pulse_model;
  logic [31:0] lfsr_model;

  logic [PFB:0] phase_queue [$];
  logic signed [15:0] sample_queue [$];
  int fail_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  logic no_idle = 1'b0;

  function automatic void build_rom();
    longint unsigned x, x2, term, pos, neg, s;
    for (int i = 0; i <= QN; i++) begin
      x = (PI_HALF_Q30 * longint'(i)) >> STB;
      x2 = (x * x) >> 30;
      term = x;
      pos = 0;
      neg = 0;
      for (int k = 0; k < 14; k++) begin
        if (k % 2 == 1) neg += term;
        else pos += term;
        term = ((term * x2) >> 30) / longint'((2 * k + 2) * (2 * k + 3));
      end
      s = (pos > neg) ? pos - neg : 0;
      quarter_rom[i] = int'((s + (64'd1 << 15)) >> 16);
    end
  endfunction

  function automatic int sine_at(logic [PFB-1:0] c);
    logic [STB+1:0] a;
    int v;
    a = c >> (PFB - STB - 2);
    v = a[STB] ? quarter_rom[QN - int'(a[STB-1:0])] : quarter_rom[a[STB-1:0]];
    return a[STB+1] ? -v : v;
  endfunction

  // round half up of coef * b / 2^14
  function automatic int bend_term(int b);
    longint p;
    p = longint'(BEND_COEF) * longint'(b) + 64'sd8192;
    return int'(p >>> 14);
  endfunction

  function automatic logic signed [15:0] next_sample(logic [PFB:0] ph);
    logic [PFB-1:0] c;
    logic [PFB-1:0] t;
    logic second;
    logic first_half;
    logic [31:0] r;
    int s;
    c = ph[PFB-1:0];
    second = ph[PFB];
    first_half = !c[PFB-1];
    case (wave_model)
      WAVE_SINE: s = sine_at(c);
      WAVE_SQUARE: s = first_half ? int'(Q_ONE) : -int'(Q_ONE);
      WAVE_FOLD: begin
        t = 3 * c + (1 << (PFB - 1));
        s = sine_at(t);
      end
      WAVE_BENT: begin
        t = 3 * c;
        s = sine_at(c) + bend_term(sine_at(t));
      end
      WAVE_PULSE: begin
        s = ((longint'(c) << 16) < (longint'(pulse_model) << PFB)) ?
            int'(Q_ONE) : -int'(Q_ONE);
      end
      WAVE_SUB: begin
        if (first_half) s = second ? int'(Q_FIFTH) : int'(Q_ONE);
        else s = second ? -int'(Q_ONE) : -int'(Q_FIFTH);
      end
      WAVE_SAW: begin
        t = c + (1 << (PFB - 1));
        s = int'(t >> (PFB - 15)) - int'(Q_ONE);
      end
      default: begin
        r = lfsr_model;
        if (r == 0) r = LFSR_SEED;
        r = r[0] ? ((r >> 1) ^ LFSR_MASK) : (r >> 1);
        lfsr_model = r;
        s = int'(r >> 17) - int'(Q_ONE);
      end
    endcase
    return s[15:0];
  endfunction

  function automatic logic [PFB:0] pick_phase(logic [15:0] pw);
    case ($urandom_range(0, 7))
      0: return {1'($urandom), pw};
      1: return {1'($urandom), pw - 16'd1};
      2: return {1'($urandom), pw + 16'd1};
      3: return {1'($urandom), 2'($urandom), ($urandom_range(0, 1) ? 14'h3FFF : 14'h0000)};
      default: return (PFB + 1)'($urandom);
    endcase
  endfunction

  task automatic check_sample(logic signed [15:0] got);
    logic signed [15:0] want;
    if (sample_queue.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected sample %0d with no request pending", got);
    end else begin
      want = sample_queue.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10) $display("sample mismatch: expected %0d, got %0d", want, got);
      end
    end
  endtask

  // phase request driver
  always @(posedge clk) begin
    if (rst) begin
      phase_valid <= 1'b0;
      gap_left <= 0;
    end else if (!phase_valid || !phase_stall) begin
      if (phase_valid) sample_queue.push_back(next_sample(phase));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        phase_valid <= 1'b0;
      end else if (phase_queue.size() > 0) begin
        phase <= phase_queue.pop_front();
        phase_valid <= 1'b1;
        gap_left <= no_idle ? 0 : $urandom_range(0, 4);
      end else begin
        phase_valid <= 1'b0;
      end
    end
  end

  // sample monitor with random back-pressure
  always @(posedge clk) begin : sample_monitor
    int draw;
    draw = no_idle ? 0 : $urandom_range(0, 4);
    if (rst) begin
      sample_stall <= 1'b0;
      stall_left <= 0;
    end else if (sample_valid && !sample_stall) begin
      check_sample(sample);
      stall_left <= draw;
      sample_stall <= (draw != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      sample_stall <= (stall_left > 1);
    end
  end

  task automatic set_reg(logic idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_WAVE_SELECT) wave_model = wave_t'(data[2:0]);
    else pulse_model = data;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (phase_queue.size() != 0 || phase_valid || sample_queue.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] wave_word(wave_t w);
    return {13'($urandom), 3'(w)};
  endfunction

  initial begin
    wave_t w;
    logic [15:0] pw;
    int offset;
    build_rom();
    wave_model = WAVE_RESET;
    pulse_model = PULSE_RESET;
    lfsr_model = LFSR_SEED;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: square
    phase_queue.push_back(0); phase_queue.push_back(32767);
    phase_queue.push_back(32768); phase_queue.push_back(131071);
    wait_idle();
    set_reg(CFG_WAVE_SELECT, wave_word(WAVE_SINE));
    phase_queue.push_back(16384); phase_queue.push_back(49151); phase_queue.push_back(65535);
    wait_idle();
    set_reg(CFG_WAVE_SELECT, wave_word(WAVE_FOLD));
    phase_queue.push_back(0); phase_queue.push_back(21845);
    wait_idle();
    set_reg(CFG_WAVE_SELECT, wave_word(WAVE_BENT));
    phase_queue.push_back(5461); phase_queue.push_back(98303);
    wait_idle();
    set_reg(CFG_WAVE_SELECT, wave_word(WAVE_PULSE));
    set_reg(CFG_PULSE_WIDTH, 16'h0000);
    phase_queue.push_back(0);
    wait_idle();
    set_reg(CFG_PULSE_WIDTH, 16'hFFFF);
    phase_queue.push_back(65534); phase_queue.push_back(65535);
    wait_idle();
    set_reg(CFG_WAVE_SELECT, wave_word(WAVE_SUB));
    phase_queue.push_back(0); phase_queue.push_back(32768);
    phase_queue.push_back(65536); phase_queue.push_back(98304);
    wait_idle();
    set_reg(CFG_WAVE_SELECT, wave_word(WAVE_SAW));
    phase_queue.push_back(0); phase_queue.push_back(32767);
    phase_queue.push_back(32768); phase_queue.push_back(65535);
    wait_idle();
    set_reg(CFG_WAVE_SELECT, wave_word(WAVE_NOISE));
    phase_queue.push_back(0); phase_queue.push_back(131071); phase_queue.push_back(65536);
    wait_idle();

    // random settings, each waveform twice
    offset = $urandom_range(0, 7);
    for (int blk = 0; blk < 16; blk++) begin
      w = wave_t'((blk + offset) % 8);
      case ($urandom_range(0, 3))
        0: pw = 16'h0000;
        1: pw = 16'hFFFF;
        default: pw = 16'($urandom);
      endcase
      if ($urandom_range(0, 1)) begin
        set_reg(CFG_WAVE_SELECT, wave_word(w));
        set_reg(CFG_PULSE_WIDTH, pw);
      end else begin
        set_reg(CFG_PULSE_WIDTH, pw);
        set_reg(CFG_WAVE_SELECT, wave_word(w));
      end
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 25; n++) phase_queue.push_back(pick_phase(pw));
      wait_idle();
    end

    no_idle = 1'b0;
    wait_idle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
